FILE: rtl/hex_string_to_integer_parser_macros.svh
// ----------------------------------------------------------------------------
// hex string parser assertion macros
// shared concurrent assertion forms for the parser checker
// ----------------------------------------------------------------------------
`ifndef HEX_STRING_TO_INTEGER_PARSER_MACROS_SVH
`define HEX_STRING_TO_INTEGER_PARSER_MACROS_SVH

// property checked at every edge outside reset
`define HSIP_ASSERT_ACTIVE(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("hsip assertion failed");

// property checked at every edge, reset included
`define HSIP_ASSERT_ALWAYS(label, clk, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("hsip assertion failed");

`endif

FILE: rtl/hsip_pkg.sv
// ----------------------------------------------------------------------------
// hsip_pkg
// types and character codes shared by the hex string parser
// ----------------------------------------------------------------------------
package hsip_pkg;

  localparam int CHAR_W  = 8;
  localparam int VALUE_W = 32;
  localparam int DIGIT_W = 4;

  localparam logic [CHAR_W-1:0] CH_NUL   = 8'h00;
  localparam logic [CHAR_W-1:0] CH_TAB   = 8'h09;
  localparam logic [CHAR_W-1:0] CH_LF    = 8'h0A;
  localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
  localparam logic [CHAR_W-1:0] CH_PLUS  = 8'h2B;
  localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;

  // letter codes a-f / A-F carry their value minus nine in the low nibble
  localparam logic [DIGIT_W-1:0] LETTER_OFFSET = 4'd9;

  typedef struct packed {
    logic               is_nul;
    logic               is_ws;
    logic               is_sign;
    logic               is_minus;
    logic               is_digit;
    logic [DIGIT_W-1:0] digit;
  } class_t;

endpackage

FILE: rtl/hsip_classify.sv
// ----------------------------------------------------------------------------
// hsip_classify
// sorts one character into nul, whitespace, sign or hex digit
// ----------------------------------------------------------------------------
module hsip_classify
  import hsip_pkg::*;
(
  input  logic [CHAR_W-1:0] character,
  output class_t            cls
);

  logic is_dec;
  logic is_letter;

  always_comb begin
    is_dec    = character inside {[8'h30:8'h39]};
    is_letter = character inside {[8'h41:8'h46], [8'h61:8'h66]};

    cls.is_nul   = (character == CH_NUL);
    cls.is_ws    = (character == CH_SPACE) || (character == CH_TAB) || (character == CH_LF);
    cls.is_sign  = (character == CH_PLUS) || (character == CH_MINUS);
    cls.is_minus = (character == CH_MINUS);
    cls.is_digit = is_dec || is_letter;
    cls.digit    = is_letter ? (character[DIGIT_W-1:0] + LETTER_OFFSET)
                             : character[DIGIT_W-1:0];
  end

endmodule

FILE: rtl/hsip_update.sv
// ----------------------------------------------------------------------------
// hsip_update
// parser state, emit decision and signed result for one character
// ----------------------------------------------------------------------------
module hsip_update
  import hsip_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               advance,
  input  class_t             cls,
  input  logic               last,
  output logic               fire,
  output logic [VALUE_W-1:0] result
);

  logic               started;
  logic               negative;
  logic [VALUE_W-1:0] accumulator;
  logic               emitted;

  logic               started_next;
  logic               negative_next;
  logic [VALUE_W-1:0] accumulator_next;

  always_comb begin
    started_next     = started;
    negative_next    = negative;
    accumulator_next = accumulator;
    fire             = 1'b0;
    if (!emitted) begin
      if (cls.is_nul) begin
        fire = 1'b1;
      end else if (cls.is_ws) begin
        fire = started;
      end else if (cls.is_sign) begin
        if (started) begin
          fire = 1'b1;
        end else begin
          started_next  = 1'b1;
          negative_next = cls.is_minus;
        end
      end else if (cls.is_digit) begin
        started_next     = 1'b1;
        accumulator_next = {accumulator[VALUE_W-DIGIT_W-1:0], cls.digit};
      end
      if (last) begin
        fire = 1'b1;
      end
    end
    result = negative_next ? ({VALUE_W{1'b0}} - accumulator_next) : accumulator_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      started     <= 1'b0;
      negative    <= 1'b0;
      accumulator <= '0;
      emitted     <= 1'b0;
    end else if (advance) begin
      if (last) begin
        started     <= 1'b0;
        negative    <= 1'b0;
        accumulator <= '0;
        emitted     <= 1'b0;
      end else begin
        started     <= started_next;
        negative    <= negative_next;
        accumulator <= accumulator_next;
        emitted     <= emitted | fire;
      end
    end
  end

endmodule

FILE: rtl/hex_string_to_integer_parser.sv
// ----------------------------------------------------------------------------
// hex_string_to_integer_parser: streaming signed 32-bit hex string parser
// path: the last char beat of a value passes the input register, then the value is held in the result register
// throughput: one char beat per cycle while char_stall is low; the update is one register-to-register pass
// reset: rst (sync, active high) clears parser state and both valid flags
// ----------------------------------------------------------------------------
module hex_string_to_integer_parser
  import hsip_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst,
  // char channel
  input  logic                      char_valid,
  output logic                      char_stall,
  input  logic [CHAR_W-1:0]         character,
  input  logic                      end_of_string,
  // result channel
  output logic                      result_valid,
  input  logic                      result_stall,
  output logic signed [VALUE_W-1:0] value
);

  // input stage: one char beat waiting for the update pass
  logic              stage_valid;
  logic [CHAR_W-1:0] char_reg;
  logic              last_reg;

  class_t             cls;
  logic               fire;
  logic [VALUE_W-1:0] result;
  logic               can_go;
  logic               advance;

  hsip_classify u_classify (
    .character (char_reg),
    .cls       (cls)
  );

  hsip_update u_update (
    .clk     (clk),
    .rst     (rst),
    .advance (advance),
    .cls     (cls),
    .last    (last_reg),
    .fire    (fire),
    .result  (result)
  );

  // a beat that emits nothing always moves on; an emitting beat needs the
  // result register empty or draining this cycle
  assign can_go     = !fire || !result_valid || !result_stall;
  assign advance    = stage_valid && can_go;
  assign char_stall = stage_valid && !can_go;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (char_valid && !char_stall) begin
      stage_valid <= 1'b1;
    end else if (advance) begin
      stage_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (char_valid && !char_stall) begin
      char_reg <= character;
      last_reg <= end_of_string;
    end
  end

  // result register: holds a finished value while the consumer stalls,
  // so the input side keeps taking beats that emit nothing
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (advance && fire) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && fire) begin
      value <= $signed(result);
    end
  end

endmodule

FILE: rtl/hsip_checker.sv
// ----------------------------------------------------------------------------
// hsip_checker
// port-level checks for the hex string parser, bound to the top level
// ----------------------------------------------------------------------------
`include "hex_string_to_integer_parser_macros.svh"

module hsip_checker
  import hsip_pkg::*;
(
  input logic                      clk,
  input logic                      rst,
  input logic                      char_stall,
  input logic                      result_valid,
  input logic                      result_stall,
  input logic signed [VALUE_W-1:0] value
);

  // a stalled result stays offered
  `HSIP_ASSERT_ACTIVE(a_result_held, clk, rst, result_valid && result_stall |=> result_valid)
  // a stalled result keeps its value
  `HSIP_ASSERT_ACTIVE(a_value_held, clk, rst, result_valid && result_stall |=> $stable(value))
  // input backpressure only comes from a full, stalled result register
  `HSIP_ASSERT_ALWAYS(a_stall_cause, clk, char_stall |-> result_valid && result_stall)
  // reset empties the result register
  `HSIP_ASSERT_ALWAYS(a_reset_empty, clk, rst |=> !result_valid)

endmodule

bind hex_string_to_integer_parser hsip_checker u_hsip_checker (
  .clk          (clk),
  .rst          (rst),
  .char_stall   (char_stall),
  .result_valid (result_valid),
  .result_stall (result_stall),
  .value        (value)
);
